// ===== rtl/vsd_pkg.sv =====
// Shared types, constants and key arithmetic for the Vigenere stream decipher.
// No dependencies.
package vsd_pkg;

  localparam logic [7:0] CHAR_UA   = 8'h41;
  localparam logic [7:0] CHAR_UZ   = 8'h5a;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LZ   = 8'h7a;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  localparam logic [7:0]  SPAN_ALPHA  = 8'd26;
  localparam logic [7:0]  SPAN_DIGIT  = 8'd10;
  // floor(a * RECIP / 2^11) == floor(a / span) for a <= 190
  localparam logic [15:0] RECIP_ALPHA = 16'd79;
  localparam logic [15:0] RECIP_DIGIT = 16'd205;
  localparam int          RECIP_SHIFT = 11;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0]        msg;
    logic signed [5:0] rem_alpha;
    logic signed [4:0] rem_digit;
  } vsd_entry_t;

  typedef struct packed {
    logic signed [5:0] rem_alpha;
    logic signed [4:0] rem_digit;
  } vsd_rem_t;

  // Uppercased key byte minus 'A', range -65 to 190.
  function automatic logic signed [8:0] key_shift(input logic [7:0] kb);
    logic [7:0] up;
    begin
      up = ((kb >= CHAR_LA) && (kb <= CHAR_LZ)) ? kb - CASE_DIFF : kb;
      key_shift = $signed({1'b0, up}) - $signed({1'b0, CHAR_UA});
    end
  endfunction

  // Remainders by 26 and by 10, truncated toward zero.
  function automatic vsd_rem_t key_rem(input logic signed [8:0] k);
    logic [7:0]  a;
    logic [15:0] pa;
    logic [15:0] pd;
    logic [4:0]  qa;
    logic [4:0]  qd;
    logic [7:0]  ma;
    logic [7:0]  md;
    vsd_rem_t    r;
    begin
      a  = k[8] ? 8'(-k) : k[7:0];
      pa = 16'(a) * RECIP_ALPHA;
      pd = 16'(a) * RECIP_DIGIT;
      qa = pa[15:RECIP_SHIFT];
      qd = pd[15:RECIP_SHIFT];
      ma = a - 8'(8'({3'b000, qa}) * SPAN_ALPHA);
      md = a - 8'(8'({3'b000, qd}) * SPAN_DIGIT);
      r.rem_alpha = k[8] ? -$signed({1'b0, ma[4:0]}) : $signed({1'b0, ma[4:0]});
      r.rem_digit = k[8] ? -$signed({1'b0, md[3:0]}) : $signed({1'b0, md[3:0]});
      key_rem = r;
    end
  endfunction

endpackage

// ===== rtl/vsd_in_if.sv =====
// Input channel: valid/ready handshake with one decipher or key-write item.
// No dependencies.
interface vsd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;
  logic [7:0] key_index;
  logic       message_start;

  modport source (output valid, func, in_byte, key_index, message_start, input ready);
  modport sink (input valid, func, in_byte, key_index, message_start, output ready);
endinterface

// ===== rtl/vsd_out_if.sv =====
// Output channel: valid/ready handshake with one deciphered byte.
// No dependencies.
interface vsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink (input valid, out_byte, output ready);
endinterface

// ===== rtl/vsd_front.sv =====
// Front end: accepts items, tracks key position, owns the key store and key length.
// Depends on vsd_pkg and vsd_in_if.
module vsd_front import vsd_pkg::*; #(
  parameter int KEY_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vsd_in_if.sink     in_i,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_data_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output vsd_entry_t push_data_o
);

  localparam int AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LW0   = $clog2(KEY_DEPTH + 1);
  localparam int LW    = (LW0 > 9) ? LW0 : 9;
  localparam logic [LW-1:0] DEPTH_L = LW'(KEY_DEPTH);

  logic [7:0]    mem [KEY_DEPTH];
  logic [8:0]    len_q;
  logic [AW-1:0] pos_q, pos_d, pos_cur;
  logic          s1_valid_q;
  logic [7:0]    msg_q;
  logic [7:0]    kb_q;
  logic          accept;
  logic          dec_acc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [LW-1:0] len_act;
  logic [LW-1:0] pos_inc;
  vsd_rem_t      rem;

  assign in_i.ready = !s1_valid_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign dec_acc    = accept && !in_i.func;
  assign pos_cur    = in_i.message_start ? '0 : pos_q;
  assign wr_en      = accept && in_i.func && (32'(in_i.key_index) < KEY_DEPTH);

  generate
    if (AW >= 8) begin : g_wide
      assign wr_addr = AW'(in_i.key_index);
    end else begin : g_narrow
      assign wr_addr = in_i.key_index[AW-1:0];
    end
  endgenerate

  always_comb begin
    len_act = LW'(len_q);
    if (len_q == 9'd0) begin
      len_act = LW'(1);
    end else if (LW'(len_q) > DEPTH_L) begin
      len_act = DEPTH_L;
    end
  end

  assign pos_inc = LW'(pos_cur) + LW'(1);

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (in_i.func) begin
        pos_d = pos_cur;
      end else if (pos_inc >= len_act) begin
        pos_d = '0;
      end else begin
        pos_d = pos_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= 9'd1;
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      pos_q <= pos_d;
      if (in_i.ready) begin
        s1_valid_q <= dec_acc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_i.in_byte;
    end
    if (dec_acc) begin
      kb_q  <= mem[pos_cur];
      msg_q <= in_i.in_byte;
    end
  end

  assign rem                   = key_rem(key_shift(kb_q));
  assign push_valid_o          = s1_valid_q;
  assign push_data_o.msg       = msg_q;
  assign push_data_o.rem_alpha = rem.rem_alpha;
  assign push_data_o.rem_digit = rem.rem_digit;

endmodule

// ===== rtl/vsd_queue.sv =====
// Two-entry queue between front and back end.
// Depends on vsd_pkg.
module vsd_queue import vsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  vsd_entry_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output vsd_entry_t pop_data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  vsd_entry_t    ent_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push;
  logic          pop;

  assign push_ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = ent_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + PW'(1);
    end
    if (pop) begin
      rd_d = (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/vsd_back.sv =====
// Back end: classifies the message byte, shifts it back, drives the output register.
// Depends on vsd_pkg and vsd_out_if.
module vsd_back import vsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  vsd_entry_t pop_data_i,
  vsd_out_if.source  out_o
);

  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic [7:0]        res_d;
  logic [7:0]        c;
  logic [7:0]        base;
  logic [7:0]        span;
  logic signed [5:0] r;
  logic              is_lower, is_upper, is_digit;
  logic signed [9:0] diff;
  logic signed [9:0] wrapped;

  assign c        = pop_data_i.msg;
  assign is_lower = (c >= CHAR_LA) && (c <= CHAR_LZ);
  assign is_upper = (c >= CHAR_UA) && (c <= CHAR_UZ);
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

  always_comb begin
    base = CHAR_ZERO;
    span = SPAN_DIGIT;
    r    = 6'(pop_data_i.rem_digit);
    if (is_lower) begin
      base = CHAR_LA;
      span = SPAN_ALPHA;
      r    = pop_data_i.rem_alpha;
    end else if (is_upper) begin
      base = CHAR_UA;
      span = SPAN_ALPHA;
      r    = pop_data_i.rem_alpha;
    end
  end

  assign diff    = $signed({2'b00, c}) - 10'(r);
  assign wrapped = diff + $signed({2'b00, span});

  always_comb begin
    res_d = c;
    if (is_lower || is_upper || is_digit) begin
      res_d = (diff < $signed({2'b00, base})) ? wrapped[7:0] : diff[7:0];
    end
  end

  assign pop_ready_o = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      out_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) begin
      out_byte_q <= res_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;

endmodule

// ===== rtl/vigenere_stream_decipher.sv =====
// Vigenere stream decipher top level: front end, two-entry queue, back end.
// A decipher item is held in the registered key store read, then in a queue entry
// and then in the output register before its result shows.
// Throughput: one item per cycle while out_o.ready is not held low; key writes give no result.
// Reset: position zero, key length 1, pipeline empty; key store undefined until written.
// Depends on vsd_pkg, vsd_in_if, vsd_out_if, vsd_front, vsd_queue, vsd_back.
module vigenere_stream_decipher import vsd_pkg::*; #(
  parameter int KEY_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vsd_in_if.sink     in_i,
  vsd_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_data_i
);

  logic       f_valid, f_ready;
  vsd_entry_t f_data;
  logic       b_valid, b_ready;
  vsd_entry_t b_data;

  vsd_front #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_data_o  (f_data)
  );

  vsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  vsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (b_valid),
    .pop_ready_o (b_ready),
    .pop_data_i  (b_data),
    .out_o       (out_o)
  );

endmodule
